// ===== src/sbpc_pkg.sv =====
// shared types, constants and helpers of the spectral band peak colorizer
// used by the serial divider, the colour mapper and the top level
package sbpc_pkg;

    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 12;
    localparam int COUNT_W    = 6;

    // register select, taken from paddr[2]
    localparam logic REG_PEAK_FLOOR = 1'b0;
    localparam logic REG_RATIO      = 1'b1;

    // fixed hue of each band
    localparam logic [2:0] HUE_RED     = 3'd0;
    localparam logic [2:0] HUE_GREEN   = 3'd1;
    localparam logic [2:0] HUE_BLUE    = 3'd2;
    localparam logic [2:0] HUE_YELLOW  = 3'd3;
    localparam logic [2:0] HUE_MAGENTA = 3'd4;
    localparam logic [2:0] HUE_CYAN    = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUPD_GO,
        ST_DUPD_WAIT,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_NORM_GO,
        ST_NORM_WAIT,
        ST_MUL,
        ST_DECIDE,
        ST_FINISH
    } sbpc_state_t;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
    } sbpc_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sbpc_div_status_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } sbpc_rgb_t;

    // x / 9 for x below 2048, by reciprocal multiply
    function automatic logic [7:0] div9(input logic [10:0] x);
        logic [24:0] p;
        p = {14'b0, x} * 25'd7282;
        return p[23:16];
    endfunction

endpackage

// ===== src/sbpc_serdiv.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on sbpc_pkg for widths and the control and status structs
module sbpc_serdiv
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbpc_pkg::sbpc_div_ctrl_t            ctrl,
    input  logic [sbpc_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [sbpc_pkg::DIVISOR_W-1:0]      divisor,
    output sbpc_pkg::sbpc_div_status_t          status,
    output logic [sbpc_pkg::DIVIDEND_W-1:0]     quotient
);

    logic [sbpc_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [sbpc_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [sbpc_pkg::DIVISOR_W-1:0]  dsr_reg;
    logic [sbpc_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [sbpc_pkg::DIVISOR_W:0]    shifted;
    logic [sbpc_pkg::DIVISOR_W:0]    diff;
    logic                            fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[sbpc_pkg::DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = ctrl.count;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[sbpc_pkg::DIVISOR_W-1:0]
                            : shifted[sbpc_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[sbpc_pkg::DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == sbpc_pkg::COUNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (ctrl.start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && !$past(done_reg))
        else $error("divider done while still running");

    a_zero_count_never: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> ctrl.count != '0)
        else $error("divider started with no steps");

endmodule

// ===== src/sbpc_colour.sv =====
// maps a band energy to an rgb colour with a fixed hue for bands 0 to 5, grey for the others
// depends on sbpc_pkg for the hue codes, the rgb struct and div9
module sbpc_colour
(
    input  logic [2:0]          band,
    input  logic [7:0]          energy,
    output sbpc_pkg::sbpc_rgb_t rgb
);

    logic [7:0] common;
    logic [8:0] three_common;
    logic [8:0] rest_wide;
    logic [7:0] rest;
    logic [7:0] half;
    logic [7:0] other;
    logic [7:0] rf, gf, bf;

    always_comb
    begin
        common       = sbpc_pkg::div9({2'b0, energy, 1'b0});
        three_common = {1'b0, common} + {common, 1'b0};
        rest_wide    = {1'b0, energy} - three_common;
        rest         = rest_wide[7:0];
        half         = {1'b0, rest[7:1]};
        other        = rest - half;
        rf = '0;
        gf = '0;
        bf = '0;
        case (band)
            sbpc_pkg::HUE_RED:     rf = rest;
            sbpc_pkg::HUE_GREEN:   gf = rest;
            sbpc_pkg::HUE_BLUE:    bf = rest;
            sbpc_pkg::HUE_YELLOW:
            begin
                rf = half;
                gf = other;
            end
            sbpc_pkg::HUE_MAGENTA:
            begin
                rf = half;
                bf = other;
            end
            sbpc_pkg::HUE_CYAN:
            begin
                gf = half;
                bf = other;
            end
            default: ;
        endcase
        rgb.red   = rf + common;
        rgb.green = gf + common;
        rgb.blue  = bf + common;
    end

endmodule

// ===== src/spectral_band_peak_colorizer.sv =====
// spectral band peak colorizer: one colour word out for each band word in
// the shared bit-serial divider runs 18, 34 and 28 steps for the divisor, average and
// normalisation divisions; one word is worked on at a time, and the output register
// holds a finished word while the next word is taken in and worked on
// reset: asynchronous, clears divisor and all band state, loads register defaults
module spectral_band_peak_colorizer
#(
    parameter int BAND_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // band_index[2:0], band_value[18:3], zero fill
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_band[2:0], red[10:3], green[18:11],
                                        // blue[26:19], zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    sbpc_pkg::sbpc_state_t state_reg, state_next;

    logic [15:0] floor_reg;
    logic [7:0]  ratio_reg;
    logic [11:0] divisor_reg;

    logic [27:0] avg_mem_reg    [BAND_COUNT];
    logic [15:0] peak_mem_reg   [BAND_COUNT];
    logic [7:0]  energy_mem_reg [BAND_COUNT];

    logic [2:0]  band_reg;
    logic [15:0] value_reg;
    logic        start_reg;
    logic [27:0] avg_work_reg;
    logic [15:0] peak_dec_reg;
    logic [7:0]  energy_dec_reg;
    logic [27:0] norm_reg;
    logic [35:0] prod_reg;
    sbpc_pkg::sbpc_rgb_t colour_reg;

    logic                out_valid_reg;
    logic [2:0]          out_band_reg;
    sbpc_pkg::sbpc_rgb_t out_rgb_reg;

    sbpc_pkg::sbpc_div_ctrl_t                div_ctrl;
    sbpc_pkg::sbpc_div_status_t              div_status;
    logic [sbpc_pkg::DIVIDEND_W-1:0]         div_dividend;
    logic [sbpc_pkg::DIVISOR_W-1:0]          div_divisor;
    logic [sbpc_pkg::DIVIDEND_W-1:0]         div_quotient;

    logic              in_accept;
    logic              cfg_write;
    logic              band_ok;
    logic [IDX_W-1:0]  idx;
    logic              out_free;
    logic              fire;
    logic [7:0]        energy_final;
    logic [17:0]       divisor_x49;
    logic [33:0]       avg_x49;
    logic [33:0]       avg_sum;
    logic [15:0]       peak_cur;
    sbpc_pkg::sbpc_rgb_t rgb_calc;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign band_ok   = {1'b0, band_reg} < 4'(BAND_COUNT);
    assign idx       = band_reg[IDX_W-1:0];
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign divisor_x49 = {6'b0, divisor_reg} * 18'd49;
    assign avg_x49     = {6'b0, avg_mem_reg[idx]} * 34'd49;
    assign avg_sum     = div_quotient + ({18'b0, value_reg} * 34'd50);
    assign peak_cur    = peak_mem_reg[idx];

    // peak test; floor(p/16) < v is the same as p < 16v
    assign fire = (value_reg > peak_dec_reg) && (value_reg >= floor_reg)
               && (prod_reg < {16'b0, value_reg, 4'b0});
    assign energy_final = fire ? 8'd255 : energy_dec_reg;

    sbpc_serdiv u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    sbpc_colour u_colour
    (
        .band   (band_reg),
        .energy (energy_final),
        .rgb    (rgb_calc)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbpc_pkg::ST_IDLE:
                if (in_accept)
                begin
                    state_next = s_axis_tuser ? sbpc_pkg::ST_DUPD_GO : sbpc_pkg::ST_AVG_GO;
                end
            sbpc_pkg::ST_DUPD_GO:   state_next = sbpc_pkg::ST_DUPD_WAIT;
            sbpc_pkg::ST_DUPD_WAIT:
                if (div_status.done)
                begin
                    state_next = sbpc_pkg::ST_AVG_GO;
                end
            sbpc_pkg::ST_AVG_GO:
                state_next = band_ok ? sbpc_pkg::ST_AVG_WAIT : sbpc_pkg::ST_FINISH;
            sbpc_pkg::ST_AVG_WAIT:
                if (div_status.done)
                begin
                    state_next = sbpc_pkg::ST_NORM_GO;
                end
            sbpc_pkg::ST_NORM_GO:
                state_next = (divisor_reg == '0) ? sbpc_pkg::ST_MUL
                                                 : sbpc_pkg::ST_NORM_WAIT;
            sbpc_pkg::ST_NORM_WAIT:
                if (div_status.done)
                begin
                    state_next = sbpc_pkg::ST_MUL;
                end
            sbpc_pkg::ST_MUL:       state_next = sbpc_pkg::ST_DECIDE;
            sbpc_pkg::ST_DECIDE:    state_next = sbpc_pkg::ST_FINISH;
            sbpc_pkg::ST_FINISH:
                if (out_free)
                begin
                    state_next = sbpc_pkg::ST_IDLE;
                end
            default:                state_next = sbpc_pkg::ST_IDLE;
        endcase
    end

    // state outputs: input handshake and divider requests
    always_comb
    begin
        s_axis_tready  = 1'b0;
        div_ctrl.start = 1'b0;
        div_ctrl.count = '0;
        div_dividend   = '0;
        div_divisor    = 12'd50;
        unique case (state_reg)
            sbpc_pkg::ST_IDLE:
                s_axis_tready = 1'b1;
            sbpc_pkg::ST_DUPD_GO:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.count = sbpc_pkg::COUNT_W'(18);
                div_dividend   = {divisor_x49, 16'b0};
            end
            sbpc_pkg::ST_AVG_GO:
            begin
                div_ctrl.start = band_ok;
                div_ctrl.count = sbpc_pkg::COUNT_W'(34);
                div_dividend   = avg_x49;
            end
            sbpc_pkg::ST_NORM_GO:
            begin
                div_ctrl.start = divisor_reg != '0;
                div_ctrl.count = sbpc_pkg::COUNT_W'(28);
                div_dividend   = {avg_work_reg, 6'b0};
                div_divisor    = divisor_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbpc_pkg::ST_IDLE;
            floor_reg     <= 16'd2;
            ratio_reg     <= 8'd18;
            divisor_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BAND_COUNT; i++)
            begin
                avg_mem_reg[i]    <= '0;
                peak_mem_reg[i]   <= '0;
                energy_mem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (paddr[2] == sbpc_pkg::REG_PEAK_FLOOR)
                begin
                    floor_reg <= pwdata[15:0];
                end
                else
                begin
                    ratio_reg <= pwdata[7:0];
                end
            end
            if (state_reg == sbpc_pkg::ST_DUPD_WAIT && div_status.done)
            begin
                divisor_reg <= div_quotient[11:0] + 12'd50;
            end
            if (state_reg == sbpc_pkg::ST_DECIDE)
            begin
                avg_mem_reg[idx]    <= avg_work_reg;
                peak_mem_reg[idx]   <= fire ? value_reg : peak_dec_reg;
                energy_mem_reg[idx] <= energy_final;
            end
            if (state_reg == sbpc_pkg::ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers of the word in flight
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            band_reg  <= s_axis_tdata[2:0];
            value_reg <= s_axis_tdata[18:3];
            start_reg <= s_axis_tuser;
        end
        if (state_reg == sbpc_pkg::ST_AVG_GO)
        begin
            peak_dec_reg   <= (peak_cur == '0) ? '0 : peak_cur - 16'd1;
            energy_dec_reg <= sbpc_pkg::div9({energy_mem_reg[idx], 3'b0});
            colour_reg     <= '0;
        end
        if (state_reg == sbpc_pkg::ST_AVG_WAIT && div_status.done)
        begin
            avg_work_reg <= avg_sum[27:0];
        end
        if (state_reg == sbpc_pkg::ST_NORM_GO)
        begin
            norm_reg <= '0;
        end
        if (state_reg == sbpc_pkg::ST_NORM_WAIT && div_status.done)
        begin
            norm_reg <= div_quotient[27:0];
        end
        if (state_reg == sbpc_pkg::ST_MUL)
        begin
            prod_reg <= {8'b0, norm_reg} * {28'b0, ratio_reg};
        end
        if (state_reg == sbpc_pkg::ST_DECIDE)
        begin
            colour_reg <= rgb_calc;
        end
        if (state_reg == sbpc_pkg::ST_FINISH && out_free)
        begin
            out_band_reg <= band_reg;
            out_rgb_reg  <= colour_reg;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == sbpc_pkg::REG_RATIO)
        begin
            prdata[7:0] = ratio_reg;
        end
        else
        begin
            prdata[15:0] = floor_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_rgb_reg.blue, out_rgb_reg.green,
                            out_rgb_reg.red, out_band_reg};

    a_accept_divider_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !div_status.busy)
        else $error("word accepted while the divider is running");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == sbpc_pkg::ST_DUPD_WAIT
                          || state_reg == sbpc_pkg::ST_AVG_WAIT
                          || state_reg == sbpc_pkg::ST_NORM_WAIT))
        else $error("divider result arrived outside a wait state");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbpc_pkg::ST_DUPD_WAIT && div_status.done) |=> divisor_reg != '0)
        else $error("divisor zero after a frame start update");

    a_frame_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbpc_pkg::ST_DUPD_GO) |-> start_reg)
        else $error("divisor update without a frame start");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbpc_pkg::ST_FINISH && out_free) |=> m_axis_tvalid)
        else $error("finished word not presented");

endmodule
